>>> rtl/core/rcwt_pkg.sv
// Shared types and constants for the Reno congestion window tracker.
`default_nettype none
package rcwt_pkg;
    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_ACK  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [1:0] REG_MSS      = 2'd0;
    localparam logic [1:0] REG_ICWND    = 2'd1;
    localparam logic [1:0] REG_ISSTHR   = 2'd2;
    localparam logic [1:0] REG_TIMEOUT  = 2'd3;

    localparam logic [31:0] SERIAL_HALF   = 32'h8000_0000;
    localparam logic [1:0]  DUP_THRESHOLD = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV,
        ST_POP_RD,
        ST_POP_CHK,
        ST_DONE
    } state_t;

    // divider control/status
    typedef struct packed {
        logic        start;
        logic [31:0] dividend_hi;
        logic [31:0] dividend_lo;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

>>> rtl/core/rcwt_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module rcwt_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rcwt_pkg::div_req_t req,
    output rcwt_pkg::div_rsp_t     rsp
);
    import rcwt_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[63]} - {1'b0, dsr_reg};
        if (req.start) begin
            quo_next  = {req.dividend_hi, req.dividend_lo};
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = {rem_reg[31:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

>>> rtl/core/rcwt_seg_store.sv
// Circular store of unacknowledged segments (seqno, length).
`default_nettype none
module rcwt_seg_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_seqno,
    input  wire logic [15:0]   wr_length,
    input  wire logic [AW-1:0] rd_addr,
    output logic [31:0]        rd_seqno,
    output logic [15:0]        rd_length
);
    logic [47:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_seqno, wr_length};
        end
        {rd_seqno, rd_length} <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> rtl/core/reno_congestion_window_tracker.sv
// Top level: Reno congestion window tracker with segment store and sequencer.
//
//  channel | ports                              | direction
//  input   | s_valid/s_ready, s_action, ...     | in
//  result  | m_valid/m_ready, m_retransmit, ... | out
//  config  | APB psel/penable/pwrite/paddr/...  | in
//
// Send and tick transfers pass from DISPATCH to DONE; a new ack in avoidance
// adds a wait in the divider (one quotient bit a cycle); each popped segment
// passes POP_RD and POP_CHK through the store's registered read port.
// s_ready is high only in IDLE; the result sits in an output register and
// a stalled m_ready holds the sequencer in DONE.
// Reset (aresetn low, synchronous) loads cwnd/ssthresh/timer from the
// register reset values; the segment store needs no clearing.
`default_nettype none
module reno_congestion_window_tracker #(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [31:0] s_seq_number,
    input  wire logic [15:0] s_seg_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_retransmit,
    output logic [31:0]      m_retx_seqno,
    output logic [15:0]      m_retx_length,
    output logic [31:0]      m_window_bytes,
    output logic [31:0]      m_threshold_bytes,
    output logic [31:0]      m_base_seqno,
    output logic             m_recovering,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0] m_outstanding,
    output logic             m_store_full,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rcwt_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);

    // configuration registers
    logic [15:0] mss_reg;
    logic [31:0] icwnd_reg, issthr_reg, timeout_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mss_reg     <= 16'd512;
            icwnd_reg   <= 32'd512;
            issthr_reg  <= 32'd65535;
            timeout_reg <= 32'd1000;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MSS:     mss_reg     <= pwdata[15:0];
                REG_ICWND:   icwnd_reg   <= pwdata;
                REG_ISSTHR:  issthr_reg  <= pwdata;
                REG_TIMEOUT: timeout_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MSS:     prdata = {16'd0, mss_reg};
            REG_ICWND:   prdata = icwnd_reg;
            REG_ISSTHR:  prdata = issthr_reg;
            REG_TIMEOUT: prdata = timeout_reg;
            default:     prdata = '0;
        endcase
    end

    // tracker state
    state_t      state_reg, state_next;
    logic [31:0] cwnd_reg, cwnd_next;
    logic [31:0] ssthr_reg, ssthr_next;
    logic        fr_reg, fr_next;
    logic [1:0]  dup_reg, dup_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] timer_reg, timer_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    // latched transfer
    logic [1:0]  act_reg, act_next;
    logic [31:0] seq_reg, seq_next;
    logic [15:0] len_reg, len_next;
    // result register
    logic        retx_reg, retx_next;
    logic [31:0] rseq_reg, rseq_next;
    logic [15:0] rlen_reg, rlen_next;
    logic        full_reg, full_next;

    // store
    logic        st_wr;
    logic [31:0] rd_seq;
    logic [15:0] rd_len;

    rcwt_seg_store #(.DEPTH(WINDOW_DEPTH), .AW(AW)) u_store (
        .aclk      (aclk),
        .wr_en     (st_wr),
        .wr_addr   (tail_reg),
        .wr_seqno  (seq_reg),
        .wr_length (len_reg),
        .rd_addr   (head_reg),
        .rd_seqno  (rd_seq),
        .rd_length (rd_len)
    );

    div_req_t dreq;
    div_rsp_t drsp;
    logic [31:0] mss_sq;
    logic        div_start;

    assign mss_sq = 32'(mss_reg) * 32'(mss_reg);
    assign dreq.start       = div_start;
    assign dreq.dividend_hi = '0;
    assign dreq.dividend_lo = mss_sq;
    assign dreq.divisor     = cwnd_reg;

    rcwt_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [33:0] b);
        logic [34:0] s;
        s = 35'(a) + 35'(b);
        return (s > 35'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [AW-1:0] nidx(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + AW'(1);
    endfunction

    logic        ack_dup, ack_cover;
    logic [1:0]  dup_inc;
    logic [31:0] half_cwnd;

    assign ack_dup   = (seq_reg - base_reg) >= SERIAL_HALF;
    assign ack_cover = (seq_reg - rd_seq) < SERIAL_HALF;
    assign dup_inc   = (dup_reg < DUP_THRESHOLD) ? dup_reg + 2'd1 : dup_reg;
    assign half_cwnd = {1'b0, cwnd_reg[31:1]};

    // next-state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                if (act_reg == ACT_ACK && !ack_dup) begin
                    if (!fr_reg && cwnd_reg >= ssthr_reg && cwnd_reg != 32'd0) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_POP_RD;
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:      if (drsp.done) state_next = ST_POP_RD;
            ST_POP_RD:   state_next = ST_POP_CHK;
            ST_POP_CHK: begin
                if (cnt_reg != '0 && ack_cover) begin
                    state_next = ST_POP_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:     if (m_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath / outputs
    always_comb begin
        cwnd_next  = cwnd_reg;
        ssthr_next = ssthr_reg;
        fr_next    = fr_reg;
        dup_next   = dup_reg;
        base_next  = base_reg;
        timer_next = timer_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        act_next   = act_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        retx_next  = retx_reg;
        rseq_next  = rseq_reg;
        rlen_next  = rlen_reg;
        full_next  = full_reg;
        st_wr      = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                act_next  = s_action;
                seq_next  = s_seq_number;
                len_next  = s_seg_length;
                retx_next = 1'b0;
                rseq_next = '0;
                rlen_next = '0;
                full_next = 1'b0;
            end
            ST_DISPATCH: begin
                // rd_seq/rd_len hold the head entry here
                case (act_reg)
                    ACT_SEND: begin
                        if (cnt_reg >= DEPTH_C) begin
                            full_next = 1'b1;
                        end else begin
                            if (cnt_reg == '0) timer_next = timeout_reg;
                            st_wr     = 1'b1;
                            tail_next = nidx(tail_reg);
                            cnt_next  = cnt_reg + CW'(1);
                        end
                    end
                    ACT_ACK: begin
                        if (ack_dup) begin
                            dup_next = dup_inc;
                            if (dup_inc >= DUP_THRESHOLD) begin
                                if (fr_reg) begin
                                    cwnd_next = sat_add(cwnd_reg, 34'(mss_reg));
                                end else begin
                                    ssthr_next = half_cwnd;
                                    cwnd_next  = sat_add(half_cwnd, 34'(mss_reg) * 34'd3);
                                    fr_next    = 1'b1;
                                    if (cnt_reg != '0) begin
                                        retx_next = 1'b1;
                                        rseq_next = rd_seq;
                                        rlen_next = rd_len;
                                    end
                                end
                            end
                        end else begin
                            dup_next   = '0;
                            timer_next = timeout_reg;
                            if (fr_reg) begin
                                cwnd_next = ssthr_reg;
                                fr_next   = 1'b0;
                            end else if (cwnd_reg >= ssthr_reg && cwnd_reg != 32'd0) begin
                                div_start = 1'b1;
                            end else begin
                                cwnd_next = sat_add(cwnd_reg, 34'(mss_reg));
                            end
                        end
                    end
                    ACT_TICK: begin
                        if (cnt_reg != '0) begin
                            if (timer_reg > 32'd1) begin
                                timer_next = timer_reg - 32'd1;
                            end else begin
                                timer_next = timeout_reg;
                                retx_next  = 1'b1;
                                rseq_next  = rd_seq;
                                rlen_next  = rd_len;
                                fr_next    = 1'b0;
                                dup_next   = '0;
                                ssthr_next = half_cwnd;
                                cwnd_next  = 32'(mss_reg);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV: begin
                // quotient of a 32-bit dividend fits in 32 bits
                if (drsp.done) cwnd_next = sat_add(cwnd_reg, 34'(drsp.quotient[31:0]));
            end
            ST_POP_CHK: begin
                if (cnt_reg != '0 && ack_cover) begin
                    base_next = rd_seq + 32'(rd_len);
                    head_next = nidx(head_reg);
                    cnt_next  = cnt_reg - CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cwnd_reg  <= 32'd512;
            ssthr_reg <= 32'd65535;
            fr_reg    <= 1'b0;
            dup_reg   <= '0;
            base_reg  <= 32'd1;
            timer_reg <= 32'd1000;
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cwnd_reg  <= cwnd_next;
            ssthr_reg <= ssthr_next;
            fr_reg    <= fr_next;
            dup_reg   <= dup_next;
            base_reg  <= base_next;
            timer_reg <= timer_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
        end
        act_reg  <= act_next;
        seq_reg  <= seq_next;
        len_reg  <= len_next;
        retx_reg <= retx_next;
        rseq_reg <= rseq_next;
        rlen_reg <= rlen_next;
        full_reg <= full_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = (state_reg == ST_DONE);
    assign m_retransmit      = retx_reg;
    assign m_retx_seqno      = rseq_reg;
    assign m_retx_length     = rlen_reg;
    assign m_window_bytes    = cwnd_reg;
    assign m_threshold_bytes = ssthr_reg;
    assign m_base_seqno      = base_reg;
    assign m_recovering      = fr_reg;
    assign m_outstanding     = cnt_reg;
    assign m_store_full      = full_reg;
endmodule
`default_nettype wire
